// ----- sv/mcpb_pkg.sv -----
package mcpb_pkg;

    // input item kinds, carried on s_axis_tuser
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_DECIDE = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_PRESCAN,
        ST_ADJUST,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } t_state;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CELL_COUNT = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_STEP       = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

    localparam int unsigned VOLT_W     = 16;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned MASK_W     = 12;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 24;
    localparam int unsigned M_DATA_W   = 48;

    localparam logic [VOLT_W-1:0]  RESET_VOLTAGE   = 16'd37000;
    localparam logic [VOLT_W-1:0]  RESET_THRESHOLD = 16'd200;
    localparam logic [VOLT_W-1:0]  RESET_STEP      = 16'd50;
    localparam logic [COUNT_W-1:0] RESET_COUNT     = 4'd12;

endpackage

// ----- sv/max_cell_passive_balancer.sv -----
// Max-cell passive balancer. Keeps one voltage (100 uV/LSB) and one discharge
// flag per cell slot. Each input beat is a voltage write, a decision refresh,
// a balancing tick or the unused mode, and yields exactly one output beat with
// the indexed cell's voltage, the pack spread, the flag mask and an index
// error. All per-cell work runs on a single compare/subtract datapath that
// walks the slots one per cycle. A write passes WRITE, SCAN and DONE; a
// decide passes SCAN, DECIDE and DONE; a tick passes PRESCAN, ADJUST, SCAN,
// DECIDE and DONE; the unused mode passes SCAN and DONE. DONE loads the output
// register once it is free, and the sequencer then returns to IDLE.
// s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register and does not block the next input beat.
module max_cell_passive_balancer #(
    parameter int unsigned MAX_CELL_SLOTS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wen,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [mcpb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mcpb_pkg::S_DATA_W-1:0]     s_axis_tdata,  // cell_index, voltage
    input  logic [1:0]                        s_axis_tuser,  // mode
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mcpb_pkg::M_DATA_W-1:0]     m_axis_tdata   // cell_voltage, spread,
                                                             // balance_mask, index_error
);

    localparam int unsigned CntW = $clog2(MAX_CELL_SLOTS);
    localparam int unsigned NW   = 5;  // holds an active-cell count up to 31
    localparam logic [CntW-1:0] LastCell = CntW'(MAX_CELL_SLOTS - 1);
    localparam logic [NW-1:0]   SlotsN   = NW'(MAX_CELL_SLOTS);

    mcpb_pkg::t_state r_state, n_state;

    // configuration
    logic [mcpb_pkg::COUNT_W-1:0] r_cell_count;
    logic [mcpb_pkg::VOLT_W-1:0]  r_threshold;
    logic [mcpb_pkg::VOLT_W-1:0]  r_step;

    // cell state
    logic [mcpb_pkg::VOLT_W-1:0]  r_volt [MAX_CELL_SLOTS];
    logic [MAX_CELL_SLOTS-1:0]    r_flags;
    logic [MAX_CELL_SLOTS-1:0]    n_flags;

    // current item
    mcpb_pkg::t_mode              r_mode;
    logic [mcpb_pkg::IDX_W-1:0]   r_idx;
    logic [mcpb_pkg::VOLT_W-1:0]  r_vin;
    logic [NW-1:0]                r_n;
    logic                         r_bad;

    // scan datapath
    logic [CntW-1:0]              r_cnt;
    logic [mcpb_pkg::VOLT_W-1:0]  r_hi, r_lo, r_shown;
    logic [CntW-1:0]              r_hi_at;

    // output register
    logic                         r_m_valid;
    logic [mcpb_pkg::M_DATA_W-1:0] r_m_data;

    logic                         s_accept;
    logic                         out_free;
    logic                         scan_last;
    logic                         cur_active;
    logic [mcpb_pkg::VOLT_W-1:0]  cur_v;
    logic [mcpb_pkg::VOLT_W:0]    step_diff;
    logic [mcpb_pkg::VOLT_W-1:0]  adj_v;
    logic [mcpb_pkg::VOLT_W-1:0]  spread;
    logic [NW-1:0]                in_n;
    logic [mcpb_pkg::MASK_W-1:0]  mask;
    logic                         rdy;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;
    assign scan_last = (r_cnt == LastCell);

    // shared datapath: one cell per cycle
    assign cur_v      = r_volt[r_cnt];
    assign cur_active = (NW'(r_cnt) < r_n);
    assign step_diff  = {1'b0, cur_v} - {1'b0, r_step};
    assign adj_v      = (!step_diff[mcpb_pkg::VOLT_W]
                         && (step_diff[mcpb_pkg::VOLT_W-1:0] >= r_lo))
                        ? step_diff[mcpb_pkg::VOLT_W-1:0] : r_lo;
    assign spread     = r_hi - r_lo;

    assign in_n = (NW'(r_cell_count) > SlotsN) ? SlotsN : NW'(r_cell_count);

    for (genvar g = 0; g < mcpb_pkg::MASK_W; g++) begin : g_mask
        if (g < MAX_CELL_SLOTS) begin : g_live
            assign mask[g] = r_flags[g] && (NW'(g) < r_n);
        end else begin : g_none
            assign mask[g] = 1'b0;
        end
    end

    // decision: all flags cleared, highest cell flagged when the spread is too wide
    always_comb begin
        n_flags = '0;
        if (r_n != '0 && spread > r_threshold) begin
            n_flags[r_hi_at] = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcpb_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (mcpb_pkg::t_mode'(s_axis_tuser))
                        mcpb_pkg::MODE_WRITE: n_state = mcpb_pkg::ST_WRITE;
                        mcpb_pkg::MODE_TICK:  n_state = mcpb_pkg::ST_PRESCAN;
                        default:              n_state = mcpb_pkg::ST_SCAN;
                    endcase
                end
            end
            mcpb_pkg::ST_WRITE:   n_state = mcpb_pkg::ST_SCAN;
            mcpb_pkg::ST_PRESCAN: if (scan_last) n_state = mcpb_pkg::ST_ADJUST;
            mcpb_pkg::ST_ADJUST:  if (scan_last) n_state = mcpb_pkg::ST_SCAN;
            mcpb_pkg::ST_SCAN: begin
                if (scan_last) begin
                    if (r_mode == mcpb_pkg::MODE_DECIDE || r_mode == mcpb_pkg::MODE_TICK)
                        n_state = mcpb_pkg::ST_DECIDE;
                    else
                        n_state = mcpb_pkg::ST_DONE;
                end
            end
            mcpb_pkg::ST_DECIDE:  n_state = mcpb_pkg::ST_DONE;
            mcpb_pkg::ST_DONE:    if (out_free) n_state = mcpb_pkg::ST_IDLE;
            default:              n_state = mcpb_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        case (r_state)
            mcpb_pkg::ST_IDLE: rdy = 1'b1;
            default:           rdy = 1'b0;
        endcase
    end

    assign s_axis_tready = rdy;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mcpb_pkg::ST_IDLE;
            r_cell_count <= mcpb_pkg::RESET_COUNT;
            r_threshold  <= mcpb_pkg::RESET_THRESHOLD;
            r_step       <= mcpb_pkg::RESET_STEP;
            r_flags      <= '0;
            r_m_valid    <= 1'b0;
            r_cnt        <= '0;
            for (int i = 0; i < MAX_CELL_SLOTS; i++) begin
                r_volt[i] <= mcpb_pkg::RESET_VOLTAGE;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_wen) begin
                case (mcpb_pkg::t_reg_idx'(i_cfg_idx))
                    mcpb_pkg::REG_CELL_COUNT:
                        r_cell_count <= i_cfg_data[mcpb_pkg::COUNT_W-1:0];
                    mcpb_pkg::REG_THRESHOLD:  r_threshold <= i_cfg_data;
                    mcpb_pkg::REG_STEP:       r_step      <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == mcpb_pkg::ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {3'b000, r_bad, mask, spread, r_shown};
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                mcpb_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                end
                mcpb_pkg::ST_WRITE: begin
                    // a good index is below the active count, hence inside the slots
                    if (!r_bad) begin
                        r_volt[r_idx[CntW-1:0]] <= r_vin;
                    end
                end
                mcpb_pkg::ST_PRESCAN, mcpb_pkg::ST_SCAN: begin
                    r_cnt <= scan_last ? '0 : r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        r_hi    <= cur_active ? cur_v : '0;
                        r_lo    <= cur_active ? cur_v : '0;
                        r_hi_at <= '0;
                        r_shown <= (r_idx == '0) ? cur_v : '0;
                    end else begin
                        if (cur_active && cur_v > r_hi) begin
                            r_hi    <= cur_v;
                            r_hi_at <= r_cnt;
                        end
                        if (cur_active && cur_v < r_lo) begin
                            r_lo <= cur_v;
                        end
                        if (mcpb_pkg::IDX_W'(r_cnt) == r_idx) begin
                            r_shown <= cur_v;
                        end
                    end
                end
                mcpb_pkg::ST_ADJUST: begin
                    r_cnt <= scan_last ? '0 : r_cnt + 1'b1;
                    if (cur_active && r_flags[r_cnt]) begin
                        r_volt[r_cnt] <= adj_v;
                    end
                end
                mcpb_pkg::ST_DECIDE: begin
                    r_flags <= n_flags;
                end
                default: ;
            endcase

            // latch the accepted beat
            if (s_accept) begin
                r_mode <= mcpb_pkg::t_mode'(s_axis_tuser);
                r_idx  <= s_axis_tdata[mcpb_pkg::IDX_W-1:0];
                r_vin  <= s_axis_tdata[mcpb_pkg::IDX_W +: mcpb_pkg::VOLT_W];
                r_n    <= in_n;
                r_bad  <= (NW'(s_axis_tdata[mcpb_pkg::IDX_W-1:0]) >= in_n);
            end
        end
    end

endmodule

// ----- sv/mcpb_checker.sv -----
module mcpb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mcpb_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped or changed under stall");

    // the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after an accepted beat");

    // a decision flags at most the one highest cell
    a_mask_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[43:32]))
        else $error("more than one cell flagged");

    // no stale result comes out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind max_cell_passive_balancer mcpb_checker u_mcpb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
